// ===== rtl/core/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants of the frame time statistics unit.
// ----------------------------------------------------------------------------
package fts_pkg;

  // Field widths
  localparam int STAMP_W = 63;
  localparam int WORD_W  = 32;
  localparam int WIDE_W  = 64;
  localparam int BKT_W   = 3;

  // Shared adder width: a 64 bit value plus one guard bit
  localparam int ALU_W = WIDE_W + 1;

  // Scale constants
  localparam logic [WORD_W-1:0] US_PER_SECOND = 32'd1000000;
  localparam logic [WORD_W-1:0] FPS_SCALE     = 32'd100;
  localparam logic [WORD_W-1:0] FREQ_RESET    = 32'd10000000;

  // Histogram
  localparam int NUM_BUCKETS = 6;
  localparam int NUM_EDGES   = NUM_BUCKETS - 1;
  localparam logic [WORD_W-1:0] BUCKET_EDGES [NUM_EDGES] =
    '{32'd8400, 32'd16700, 32'd20000, 32'd33400, 32'd50000};

  // Sequencer step counts
  localparam int MUL_STEPS = WORD_W;   // one multiplier bit per step
  localparam int DIV_STEPS = 96;       // one dividend bit per step
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Request to and answer from the shared add/subtract unit
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;   // on subtract: a >= b
  } alu_rsp_t;

endpackage

// ===== rtl/core/fts_alu.sv =====
// ----------------------------------------------------------------------------
// fts_alu
// Shared 65 bit add/subtract unit used by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module fts_alu
  import fts_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   full;

  // Two's complement subtract: a + ~b + 1, carry out set when a >= b
  assign b_op = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

  assign rsp.sum   = full[ALU_W-1:0];
  assign rsp.carry = full[ALU_W];

endmodule

// ===== rtl/core/fts_hist.sv =====
// ----------------------------------------------------------------------------
// fts_hist
// Gap histogram: bucket selection and six wrapping bucket counters.
// ----------------------------------------------------------------------------
module fts_hist
  import fts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] gap,
  input  logic              inc,
  output logic [BKT_W-1:0]  bucket,
  output logic [WORD_W-1:0] count_next
);

  logic [WORD_W-1:0] counts [NUM_BUCKETS];

  // First edge above the gap picks the bucket, otherwise the slowest one
  always_comb begin
    bucket = BKT_W'(NUM_BUCKETS - 1);
    for (int i = NUM_EDGES - 1; i >= 0; i--) begin
      if (gap < BUCKET_EDGES[i]) begin
        bucket = BKT_W'(i);
      end
    end
  end

  assign count_next = counts[bucket] + 1'b1;

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        counts[i] <= '0;
      end
    end else if (inc) begin
      counts[bucket] <= count_next;
    end
  end

endmodule

// ===== rtl/core/frame_time_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// frame_time_statistics_unit
// Frame gap, maximum, total, histogram and frame rate from frame timestamps.
// ----------------------------------------------------------------------------
// Steps: a pause item goes straight to the result; other frames run the window
//   update and check. A measured gap adds the difference (redone the other way
//   when going backwards), a 32 step multiply, a 96 step divide and the update;
//   a closed window adds two 32 step multiplies, a 96 step divide and the update.
// Items: one at a time; the arithmetic steps run through one shared 65 bit
//   adder, so the multiply/divide iterations set the item time.
// Reset (rst, synchronous): statistics and histogram cleared, tick_freq back
//   to 10000000, no result pending. A finished result waits in its own register.
// ----------------------------------------------------------------------------
module frame_time_statistics_unit
  import fts_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // configuration: tick_freq
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  // input items
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // [62:0] timestamp
  input  logic [0:0]    s_axis_tuser,   // [0] kind
  // result items
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] gap_us, [63:32] max_gap_us, [127:64] total_gap_us, [130:128] bucket,
  // [162:131] bucket_count, [194:163] fps_x100
  output logic [199:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser    // [0] has_gap, [1] fps_updated
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DIFF  = 10'b00_0000_0010,
    S_NEGD  = 10'b00_0000_0100,
    S_MUL   = 10'b00_0000_1000,
    S_DIV   = 10'b00_0001_0000,
    S_GAPUP = 10'b00_0010_0000,
    S_WIN   = 10'b00_0100_0000,
    S_WCHK  = 10'b00_1000_0000,
    S_FPSUP = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Statistics state
  logic [WORD_W-1:0]  tick_freq;
  logic [STAMP_W-1:0] last_stamp;
  logic [WORD_W-1:0]  max_gap;
  logic [WIDE_W-1:0]  total_gap;
  logic [STAMP_W-1:0] window_start;
  logic [WORD_W-1:0]  window_frames;
  logic [WORD_W-1:0]  fps_value;

  // Item being worked on
  logic [STAMP_W-1:0] stamp;
  logic               neg;
  logic               span_ok;
  logic               fps_phase;
  logic               mul_second;
  logic               has_gap;
  logic               updated;
  logic [WORD_W-1:0]  gap;
  logic [BKT_W-1:0]   bucket;
  logic [WORD_W-1:0]  bucket_count;

  // Multiply/divide registers
  logic [WIDE_W-1:0]  mcand;
  logic [WIDE_W-1:0]  acc_hi;
  logic [WORD_W-1:0]  acc_lo;
  logic [WIDE_W-1:0]  rem;
  logic [WIDE_W-1:0]  divisor;
  logic [WORD_W-1:0]  quo;
  logic [CNT_W-1:0]   cnt;

  // Result register
  logic               out_valid;
  logic               o_has_gap;
  logic               o_updated;
  logic [WORD_W-1:0]  o_gap;
  logic [WORD_W-1:0]  o_max;
  logic [WIDE_W-1:0]  o_total;
  logic [BKT_W-1:0]   o_bucket;
  logic [WORD_W-1:0]  o_bcount;
  logic [WORD_W-1:0]  o_fps;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic [WORD_W-1:0]  freq_eff;
  logic [WORD_W-1:0]  gap_val;
  logic               hist_inc;
  logic [BKT_W-1:0]   hist_bucket;
  logic [WORD_W-1:0]  hist_count;
  logic               s_fire;
  logic               out_load;
  logic               mul_last;
  logic               div_last;
  logic [ALU_W-1:0]   div_rem_sh;

  assign freq_eff  = (tick_freq == '0) ? WORD_W'(1) : tick_freq;
  assign gap_val   = neg ? (~quo + 1'b1) : quo;
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state == S_FIN) && (!out_valid || m_axis_tready);
  assign mul_last  = (cnt == CNT_W'(MUL_STEPS - 1));
  assign div_last  = (cnt == CNT_W'(DIV_STEPS - 1));
  assign hist_inc  = (state == S_GAPUP);
  assign div_rem_sh = {rem, acc_hi[WIDE_W-1]};

  assign s_axis_tready = (state == S_IDLE);

  // Shared unit
  fts_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  fts_hist u_hist (
    .clk        (clk),
    .rst        (rst),
    .gap        (gap_val),
    .inc        (hist_inc),
    .bucket     (hist_bucket),
    .count_next (hist_count)
  );

  // Operand selection for the shared unit
  always_comb begin
    alu_req = '0;
    case (state)
      S_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(stamp);
        alu_req.b   = ALU_W'(last_stamp);
      end
      S_NEGD: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(last_stamp);
        alu_req.b   = ALU_W'(stamp);
      end
      S_MUL: begin
        alu_req.a = {1'b0, acc_hi};
        alu_req.b = acc_lo[0] ? {1'b0, mcand} : '0;
      end
      S_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = div_rem_sh;
        alu_req.b   = {1'b0, divisor};
      end
      S_GAPUP: begin
        alu_req.a = {1'b0, total_gap};
        alu_req.b = ALU_W'(gap_val);
      end
      S_WIN: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(stamp);
        alu_req.b   = ALU_W'(window_start);
      end
      S_WCHK: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, divisor};
        alu_req.b   = ALU_W'(freq_eff);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_freq <= FREQ_RESET;
    end else if (cfg_wr_en) begin
      tick_freq <= cfg_wr_data;
    end
  end

  // Sequencer and statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_stamp    <= '0;
      max_gap       <= '0;
      total_gap     <= '0;
      window_start  <= '0;
      window_frames <= '0;
      fps_value     <= '0;
      has_gap       <= 1'b0;
      updated       <= 1'b0;
      neg           <= 1'b0;
      span_ok       <= 1'b0;
      fps_phase     <= 1'b0;
      mul_second    <= 1'b0;
      cnt           <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            stamp        <= s_axis_tdata[STAMP_W-1:0];
            has_gap      <= 1'b0;
            updated      <= 1'b0;
            gap          <= '0;
            bucket       <= '0;
            bucket_count <= '0;
            if (s_axis_tuser[0]) begin
              last_stamp <= '0;
              state      <= S_FIN;
            end else if (last_stamp != '0) begin
              state <= S_DIFF;
            end else begin
              state <= S_WIN;
            end
          end
        end
        S_DIFF: begin
          // forward gap, or measure it the other way round
          if (alu_rsp.carry) begin
            neg       <= 1'b0;
            mcand     <= WIDE_W'(alu_rsp.sum[STAMP_W-1:0]);
            acc_hi    <= '0;
            acc_lo    <= US_PER_SECOND;
            divisor   <= WIDE_W'(freq_eff);
            fps_phase <= 1'b0;
            cnt       <= '0;
            state     <= S_MUL;
          end else begin
            neg   <= 1'b1;
            state <= S_NEGD;
          end
        end
        S_NEGD: begin
          mcand     <= WIDE_W'(alu_rsp.sum[STAMP_W-1:0]);
          acc_hi    <= '0;
          acc_lo    <= US_PER_SECOND;
          divisor   <= WIDE_W'(freq_eff);
          fps_phase <= 1'b0;
          cnt       <= '0;
          state     <= S_MUL;
        end
        S_MUL: begin
          // shift-add, one multiplier bit per step
          if (mul_last && fps_phase && !mul_second) begin
            mcand      <= {alu_rsp.sum[WORD_W:1], alu_rsp.sum[0], acc_lo[WORD_W-1:1]};
            acc_hi     <= '0;
            acc_lo     <= freq_eff;
            mul_second <= 1'b1;
            cnt        <= '0;
          end else begin
            acc_hi <= alu_rsp.sum[ALU_W-1:1];
            acc_lo <= {alu_rsp.sum[0], acc_lo[WORD_W-1:1]};
            if (mul_last) begin
              rem   <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_DIV: begin
          // restoring division, one dividend bit per step
          rem <= alu_rsp.carry ? alu_rsp.sum[WIDE_W-1:0] : div_rem_sh[WIDE_W-1:0];
          quo <= {quo[WORD_W-2:0], alu_rsp.carry};
          {acc_hi, acc_lo} <= {acc_hi[WIDE_W-2:0], acc_lo, 1'b0};
          if (div_last) begin
            state <= fps_phase ? S_FPSUP : S_GAPUP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_GAPUP: begin
          has_gap      <= 1'b1;
          gap          <= gap_val;
          bucket       <= hist_bucket;
          bucket_count <= hist_count;
          total_gap    <= alu_rsp.sum[WIDE_W-1:0];
          if (gap_val > max_gap) begin
            max_gap <= gap_val;
          end
          state <= S_WIN;
        end
        S_WIN: begin
          last_stamp    <= stamp;
          window_frames <= window_frames + 1'b1;
          divisor       <= alu_rsp.sum[WIDE_W-1:0];
          span_ok       <= alu_rsp.carry;
          state         <= S_WCHK;
        end
        S_WCHK: begin
          // window closes once its span reaches one second of ticks
          if (span_ok && alu_rsp.carry) begin
            mcand      <= WIDE_W'(window_frames);
            acc_hi     <= '0;
            acc_lo     <= FPS_SCALE;
            fps_phase  <= 1'b1;
            mul_second <= 1'b0;
            cnt        <= '0;
            state      <= S_MUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_FPSUP: begin
          fps_value     <= quo;
          window_start  <= stamp;
          window_frames <= '0;
          updated       <= 1'b1;
          state         <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_has_gap <= has_gap;
      o_updated <= updated;
      o_gap     <= gap;
      o_max     <= max_gap;
      o_total   <= total_gap;
      o_bucket  <= bucket;
      o_bcount  <= bucket_count;
      o_fps     <= fps_value;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, o_fps, o_bcount, o_bucket, o_total, o_max, o_gap};
  assign m_axis_tuser  = {o_updated, o_has_gap};

  // Checks
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("division remainder not below divisor");

  a_pause_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tuser[0]) |=> (last_stamp == '0))
    else $error("pause item did not clear last timestamp");

  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    (state == S_FPSUP) |=> (window_frames == '0 && updated))
    else $error("closed window not restarted");

  a_no_gap_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (o_gap == '0 && o_bucket == '0 && o_bcount == '0))
    else $error("gap fields set without a measured gap");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (cnt < CNT_W'(MUL_STEPS)))
    else $error("multiply step count out of range");

endmodule
